// ===== rtl/core/cuha_pkg.sv =====
// Shared types and constants for the column usage hash accumulator.
// No dependencies; used by every module in rtl/core.
package cuha_pkg;

    // Command codes (input tuser)
    localparam logic [1:0] CMD_ACCUM  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_EVICT  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Status codes (output tuser)
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_CREATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_SWEPT    = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;

    localparam logic [1:0] USAGE_BAD = 2'd3;

    localparam logic [36:0] USEC_PER_DAY  = 37'd86400000000;
    localparam logic [11:0] EVICT_MAX     = 12'd4095;
    localparam logic [11:0] WINDOW_RESET  = 12'd7;
    localparam logic [31:0] HASH_MUL      = 32'd31;

    typedef struct packed {
        logic        valid;
        logic [31:0] rel;
        logic [15:0] col;
        logic [1:0]  usage;
        logic [31:0] count;
        logic [47:0] rent;
        logic [62:0] last;
    } t_entry;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] slot;
        logic        used;
        logic [31:0] rel;
        logic [15:0] col;
        logic [1:0]  usage;
        logic [31:0] count;
        logic [47:0] rent;
        logic [62:0] last;
        logic [11:0] evicted;
    } t_result;

    // ASCII usage letters: 'p', 's', 'j'
    function automatic logic [31:0] usage_code(input logic [1:0] u);
        logic [31:0] c;
        case (u)
            2'd0:    c = 32'd112;
            2'd1:    c = 32'd115;
            2'd2:    c = 32'd106;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/cuha_hash.sv =====
// Home slot unit: 32-bit key hash, then remainder by the table size.
// Depends on cuha_pkg. Power-of-two sizes mask; others use a reciprocal multiply.
module cuha_hash #(
    parameter int TABLE_SLOTS = 2048,
    parameter int SW          = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_rel,
    input  logic [15:0]   i_col,
    input  logic [1:0]    i_usage,
    output logic          o_done,
    output logic [SW-1:0] o_home
);
    import cuha_pkg::*;

    localparam bit          IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [SW:0] MODN    = (SW+1)'(TABLE_SLOTS);
    localparam logic [31:0] QMUL    = 32'(TABLE_SLOTS);
    // floor(2^32 / N): quotient estimate is low by at most one
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_SLOTS);

    logic [31:0]   r_h;
    logic [31:0]   r_q;
    logic [SW:0]   r_r;
    logic [SW-1:0] r_rem;
    logic [1:0]    r_step;
    logic          r_busy;
    logic          r_done;

    logic [31:0]   w_hash;
    logic [63:0]   w_prod;
    logic [31:0]   w_qn;
    logic [31:0]   w_diff;
    logic [SW-1:0] n_rem;

    // rel*31*31 + sext(col)*31 + code, wrapping at 32 bits
    assign w_hash = i_rel * HASH_MUL * HASH_MUL
                  + {{16{i_col[15]}}, i_col} * HASH_MUL
                  + usage_code(i_usage);

    // step 0: quotient estimate, step 1: partial remainder (< 2N), step 2: correction
    assign w_prod = 64'(r_h) * 64'(RECIP);
    assign w_qn   = r_q * QMUL;
    assign w_diff = r_h - w_qn;
    assign n_rem  = (r_r >= MODN) ? SW'(r_r - MODN) : SW'(r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_h    <= w_hash;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (IS_POW2) begin
                    r_rem  <= r_h[SW-1:0];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    case (r_step)
                        2'd0: begin
                            r_q    <= w_prod[63:32];
                            r_step <= 2'd1;
                        end
                        2'd1: begin
                            r_r    <= w_diff[SW:0];
                            r_step <= 2'd2;
                        end
                        default: begin
                            r_rem  <= n_rem;
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

// ===== rtl/core/cuha_table.sv =====
// Slot store: one write port, one registered read port, one entry per slot.
// Depends on cuha_pkg for the entry layout.
module cuha_table #(
    parameter int TABLE_SLOTS = 2048,
    parameter int SW          = 11
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [SW-1:0]   i_rd_addr,
    output cuha_pkg::t_entry o_rd_data,
    input  logic            i_wr_en,
    input  logic [SW-1:0]   i_wr_addr,
    input  cuha_pkg::t_entry i_wr_data
);
    import cuha_pkg::*;

    t_entry r_mem [TABLE_SLOTS];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== rtl/core/column_usage_hash_accumulator.sv =====
// Column usage hash accumulator: top level with the command sequencer.
// Depends on cuha_pkg, cuha_hash and cuha_table.
//
// Usage:
//  - s_axis carries one command item; tuser holds the command, tdata the key,
//    cost, time and slot index. m_axis returns exactly one result item per
//    command; tuser holds the status, tdata the slot and entry fields.
//  - i_cfg_* writes the window (days) register; it is always ready and must
//    only be written while the block is idle.
//  - After reset the table is swept once to clear every slot's valid bit;
//    s_axis_tready stays low during the sweep.
//  - One item at a time: s_axis_tready is high only when idle.
//    Accumulate/remove: hash (a mask for a power-of-two table, else the
//    reciprocal multiply, remainder and correction steps), then one memory
//    read and one compare per probed slot, then the result is presented.
//    Read: one memory read and check of the indexed slot.
//    Evict sweep: every slot in order, one slot per read/compare pair.
//  - The result is held in an output register until m_axis_tready; the block
//    takes no new item until it is delivered.
module column_usage_hash_accumulator #(
    parameter int TABLE_SLOTS = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command item
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // command
    // relation_id, column_number, usage_kind, cost, time_us, slot_index, pad
    input  logic [167:0] s_axis_tdata,
    // result item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [2:0]   m_axis_tuser,   // status
    // slot, slot_used, entry_relation, entry_column, entry_usage, entry_count,
    // entry_rent, entry_last_seen, evicted_count, pad
    output logic [223:0] m_axis_tdata,
    // window_days register
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [11:0]  i_cfg_data
);
    import cuha_pkg::*;

    localparam int            SW   = $clog2(TABLE_SLOTS);
    localparam logic [SW-1:0] LAST = SW'(TABLE_SLOTS - 1);

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_HASH      = 10'b0000000100,
        S_PROBE_RD  = 10'b0000001000,
        S_PROBE_CHK = 10'b0000010000,
        S_SWEEP_RD  = 10'b0000100000,
        S_SWEEP_CHK = 10'b0001000000,
        S_READ_RD   = 10'b0010000000,
        S_READ_CHK  = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } t_state;

    t_state        r_state;
    logic [11:0]   r_window;
    logic [1:0]    r_cmd;
    logic [31:0]   r_rel;
    logic [15:0]   r_col;
    logic [1:0]    r_usage;
    logic [39:0]   r_cost;
    logic [62:0]   r_now;
    logic [10:0]   r_sidx;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_start;
    logic [48:0]   r_max_age;
    logic [11:0]   r_evicted;
    t_result       r_res;

    logic          w_accept;
    logic          w_hash_done;
    logic [SW-1:0] w_home;
    t_entry        w_rd;
    logic          w_wr_en;
    t_entry        w_wr;
    logic          w_match;
    logic [31:0]   w_cnt_inc;
    logic [48:0]   w_rent_sum;
    logic [47:0]   w_rent_new;
    logic [SW-1:0] w_next;
    logic [62:0]   w_age;
    logic          w_stale;
    logic          w_in_range;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_match    = (w_rd.rel == r_rel) && (w_rd.col == r_col) && (w_rd.usage == r_usage);
    assign w_cnt_inc  = (w_rd.count == 32'hFFFF_FFFF) ? w_rd.count : w_rd.count + 32'd1;
    assign w_rent_sum = {1'b0, w_rd.rent} + {9'd0, r_cost};
    assign w_rent_new = w_rent_sum[48] ? 48'hFFFF_FFFF_FFFF : w_rent_sum[47:0];
    assign w_next     = (r_idx == LAST) ? '0 : r_idx + SW'(1);
    assign w_age      = r_now - w_rd.last;
    // record stamped at zero never ages out
    assign w_stale    = w_rd.valid && (w_rd.last != 63'd0) && (r_now > w_rd.last)
                     && ({14'd0, r_max_age} < w_age);
    assign w_in_range = {21'd0, r_sidx} < TABLE_SLOTS;

    cuha_hash #(.TABLE_SLOTS(TABLE_SLOTS), .SW(SW)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_IDLE && w_accept
                  && (s_axis_tuser == CMD_ACCUM || s_axis_tuser == CMD_REMOVE)),
        .i_rel   (s_axis_tdata[31:0]),
        .i_col   (s_axis_tdata[47:32]),
        .i_usage (s_axis_tdata[49:48]),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    cuha_table #(.TABLE_SLOTS(TABLE_SLOTS), .SW(SW)) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_PROBE_RD || r_state == S_SWEEP_RD || r_state == S_READ_RD),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr)
    );

    // table write: clear pass, probe update/create/remove, sweep eviction
    always_comb begin
        w_wr_en = 1'b0;
        w_wr    = '0;
        case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
            end
            S_PROBE_CHK: begin
                w_wr.rel   = r_rel;
                w_wr.col   = r_col;
                w_wr.usage = r_usage;
                w_wr.last  = r_now;
                if (!w_rd.valid) begin
                    w_wr_en    = (r_cmd == CMD_ACCUM);
                    w_wr.valid = 1'b1;
                    w_wr.count = 32'd1;
                    w_wr.rent  = {8'd0, r_cost};
                end else if (w_match) begin
                    w_wr_en    = 1'b1;
                    w_wr.valid = (r_cmd == CMD_ACCUM);
                    w_wr.count = w_cnt_inc;
                    w_wr.rent  = w_rent_new;
                end
            end
            S_SWEEP_CHK: begin
                w_wr_en = w_stale;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_window <= WINDOW_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= w_next;
                    if (r_idx == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= s_axis_tuser;
                        r_rel     <= s_axis_tdata[31:0];
                        r_col     <= s_axis_tdata[47:32];
                        r_usage   <= s_axis_tdata[49:48];
                        r_cost    <= s_axis_tdata[89:50];
                        r_now     <= s_axis_tdata[152:90];
                        r_sidx    <= s_axis_tdata[163:153];
                        r_res     <= '0;
                        r_evicted <= '0;
                        case (s_axis_tuser)
                            CMD_EVICT: begin
                                r_idx     <= '0;
                                r_max_age <= 49'(r_window) * 49'(USEC_PER_DAY);
                                r_state   <= S_SWEEP_RD;
                            end
                            CMD_READ: begin
                                r_idx   <= SW'(s_axis_tdata[163:153]);
                                r_state <= S_READ_RD;
                            end
                            default: begin
                                if (s_axis_tdata[49:48] == USAGE_BAD) begin
                                    r_res.status <= ST_NOTFOUND;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_HASH;
                                end
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    // hash unit also runs for a bad usage; its result is ignored
                    if (w_hash_done) begin
                        if (r_usage == USAGE_BAD) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= w_home;
                            r_start <= w_home;
                            r_state <= S_PROBE_RD;
                        end
                    end
                end
                S_PROBE_RD: begin
                    r_state <= S_PROBE_CHK;
                end
                S_PROBE_CHK: begin
                    if (!w_rd.valid) begin
                        r_state <= S_OUT;
                        if (r_cmd == CMD_REMOVE) begin
                            r_res.status <= ST_NOTFOUND;
                        end else begin
                            r_res.status <= ST_CREATED;
                            r_res.slot   <= 11'(r_idx);
                            r_res.used   <= 1'b1;
                            r_res.rel    <= r_rel;
                            r_res.col    <= r_col;
                            r_res.usage  <= r_usage;
                            r_res.count  <= 32'd1;
                            r_res.rent   <= {8'd0, r_cost};
                            r_res.last   <= r_now;
                        end
                    end else if (w_match) begin
                        r_state     <= S_OUT;
                        r_res.slot  <= 11'(r_idx);
                        r_res.rel   <= w_rd.rel;
                        r_res.col   <= w_rd.col;
                        r_res.usage <= w_rd.usage;
                        if (r_cmd == CMD_REMOVE) begin
                            // removed record shown as it was, marked not live
                            r_res.status <= ST_REMOVED;
                            r_res.count  <= w_rd.count;
                            r_res.rent   <= w_rd.rent;
                            r_res.last   <= w_rd.last;
                        end else begin
                            r_res.status <= ST_UPDATED;
                            r_res.used   <= 1'b1;
                            r_res.count  <= w_cnt_inc;
                            r_res.rent   <= w_rent_new;
                            r_res.last   <= r_now;
                        end
                    end else if (w_next == r_start) begin
                        // full circle without a free slot or a match
                        r_state <= S_OUT;
                        if (r_cmd == CMD_REMOVE) begin
                            r_res.status <= ST_NOTFOUND;
                        end else begin
                            r_res.status <= ST_FULL;
                            r_res.slot   <= 11'(r_start);
                        end
                    end else begin
                        r_idx   <= w_next;
                        r_state <= S_PROBE_RD;
                    end
                end
                S_SWEEP_RD: begin
                    r_state <= S_SWEEP_CHK;
                end
                S_SWEEP_CHK: begin
                    logic [11:0] v_evicted;
                    v_evicted = (w_stale && r_evicted != EVICT_MAX)
                              ? r_evicted + 12'd1 : r_evicted;
                    r_evicted <= v_evicted;
                    r_idx     <= w_next;
                    if (r_idx == LAST) begin
                        r_res.status  <= ST_SWEPT;
                        r_res.evicted <= v_evicted;
                        r_state       <= S_OUT;
                    end else begin
                        r_state <= S_SWEEP_RD;
                    end
                end
                S_READ_RD: begin
                    r_state <= S_READ_CHK;
                end
                S_READ_CHK: begin
                    r_res.status <= ST_READ;
                    r_res.slot   <= r_sidx;
                    if (w_in_range && w_rd.valid) begin
                        r_res.used  <= 1'b1;
                        r_res.rel   <= w_rd.rel;
                        r_res.col   <= w_rd.col;
                        r_res.usage <= w_rd.usage;
                        r_res.count <= w_rd.count;
                        r_res.rent  <= w_rd.rent;
                        r_res.last  <= w_rd.last;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tdata  = {7'd0, r_res.evicted, r_res.last, r_res.rent, r_res.count,
                            r_res.usage, r_res.col, r_res.rel, r_res.used, r_res.slot};

endmodule

// ===== tb/column_usage_hash_accumulator_tb.sv =====
// Self-checking testbench for column_usage_hash_accumulator.
// Depends on cuha_pkg and the RTL under rtl/core; a local shadow hash table
// predicts every result, directed rows first, then random traffic.
`timescale 1ns / 1ps

module column_usage_hash_accumulator_tb;
    import cuha_pkg::*;

    localparam int SLOTS      = 2048;
    localparam int MAX_CYCLES = 3000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [2:0]   m_axis_tuser;
    logic [223:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [11:0]  i_cfg_data = '0;

    column_usage_hash_accumulator #(.TABLE_SLOTS(SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the table and the window register
    bit          shadow_valid [SLOTS];
    logic [49:0] shadow_key   [SLOTS];
    logic [31:0] shadow_count [SLOTS];
    logic [47:0] shadow_rent  [SLOTS];
    logic [62:0] shadow_time  [SLOTS];
    logic [11:0] shadow_window = WINDOW_RESET;

    t_result pending_results[$];
    int      mismatches = 0;
    int      status_seen [7];
    int      cycle_count = 0;
    int      items_sent = 0;
    bit      no_idle = 1'b0;     // stretch with neither side idling

    // key pool: groups share a home slot (relations differ by a multiple of 2048)
    logic [31:0] pool_rel [48];
    logic [15:0] pool_col [48];
    logic [1:0]  pool_use [48];
    logic [62:0] clock_us = 63'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] rel;
        logic [15:0] col;
        logic [1:0]  use_kind;
        logic [39:0] cost;
        logic [62:0] tm;
        logic [10:0] sidx;
        logic        chk;
        logic [2:0]  st;
    } t_row;

    localparam logic [39:0] COST_MAX = '1;
    localparam logic [62:0] TIME_MAX = '1;

    t_row directed_rows [21] = '{
        '{CMD_READ,   32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd0, 1'b1, ST_READ},
        '{CMD_REMOVE, 32'd1, 16'd0, 2'd0, 40'd0, 63'd5, 11'd0, 1'b1, ST_NOTFOUND},
        '{CMD_ACCUM,  32'd1, 16'd0, USAGE_BAD, 40'd9, 63'd5, 11'd0, 1'b1, ST_NOTFOUND},
        '{CMD_REMOVE, 32'd1, 16'd0, USAGE_BAD, 40'd9, 63'd5, 11'd0, 1'b1, ST_NOTFOUND},
        '{CMD_ACCUM,  32'hFFFFFFFF, 16'h8000, 2'd2, COST_MAX, TIME_MAX, 11'd0, 1'b1,
          ST_CREATED},
        '{CMD_ACCUM,  32'hFFFFFFFF, 16'h8000, 2'd2, COST_MAX, 63'd1, 11'd0, 1'b1,
          ST_UPDATED},
        '{CMD_READ,   32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd2047, 1'b1, ST_READ},
        '{CMD_REMOVE, 32'hFFFFFFFF, 16'h8000, 2'd2, 40'd0, 63'd0, 11'd0, 1'b1,
          ST_REMOVED},
        '{CMD_REMOVE, 32'hFFFFFFFF, 16'h8000, 2'd2, 40'd0, 63'd0, 11'd0, 1'b1,
          ST_NOTFOUND},
        '{CMD_ACCUM,  32'd0, 16'h7FFF, 2'd1, 40'd0, 63'd0, 11'd0, 1'b1, ST_CREATED},
        '{CMD_ACCUM,  32'd5, 16'd0, 2'd0, 40'd100, 63'd1000, 11'd0, 1'b1, ST_CREATED},
        '{CMD_ACCUM,  32'd2053, 16'd0, 2'd0, 40'd100, 63'd1000, 11'd0, 1'b1,
          ST_CREATED},
        '{CMD_ACCUM,  32'd4101, 16'd0, 2'd0, 40'd100, 63'd1000, 11'd0, 1'b1,
          ST_CREATED},
        '{CMD_REMOVE, 32'd2053, 16'd0, 2'd0, 40'd0, 63'd0, 11'd0, 1'b1, ST_REMOVED},
        // chain now broken in front of the third record: a second copy appears
        '{CMD_ACCUM,  32'd4101, 16'd0, 2'd0, 40'd7, 63'd2000, 11'd0, 1'b1,
          ST_CREATED},
        '{CMD_READ,   32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd821, 1'b1, ST_READ},
        '{CMD_READ,   32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd823, 1'b1, ST_READ},
        '{CMD_EVICT,  32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd0, 1'b1, ST_SWEPT},
        // sweep at the latest time: the record stamped at zero survives
        '{CMD_EVICT,  32'd0, 16'd0, 2'd0, 40'd0, TIME_MAX, 11'd0, 1'b1, ST_SWEPT},
        '{CMD_READ,   32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd2047, 1'b1, ST_READ},
        '{CMD_ACCUM,  32'd0, 16'h7FFF, 2'd1, 40'd3, 63'd9, 11'd0, 1'b1, ST_UPDATED}
    };

    function automatic logic [10:0] home_of(input logic [31:0] rel, input logic [15:0] col,
                                            input logic [1:0] use_kind);
        logic [31:0] h;
        logic [31:0] letter;
        letter = (use_kind == 2'd0) ? 32'd112 : (use_kind == 2'd1) ? 32'd115 : 32'd106;
        h = rel * 32'd31 + {{16{col[15]}}, col};
        h = h * 32'd31 + letter;
        return h[10:0];
    endfunction

    function automatic t_result with_entry(input t_result r, input int i);
        t_result o;
        o = r;
        o.rel   = shadow_key[i][31:0];
        o.col   = shadow_key[i][47:32];
        o.usage = shadow_key[i][49:48];
        o.count = shadow_count[i];
        o.rent  = shadow_rent[i];
        o.last  = shadow_time[i];
        return o;
    endfunction

    function automatic void clear_shadow(input int i);
        shadow_valid[i] = 1'b0;
        shadow_key[i]   = '0;
        shadow_count[i] = '0;
        shadow_rent[i]  = '0;
        shadow_time[i]  = '0;
    endfunction

    // advance the shadow table by one command and return its result
    function automatic t_result table_update(input logic [1:0] cmd, input logic [31:0] rel,
                                             input logic [15:0] col, input logic [1:0] uk,
                                             input logic [39:0] cost, input logic [62:0] tm,
                                             input logic [10:0] sidx);
        t_result     r;
        logic [49:0] k;
        logic [48:0] sum;
        logic [63:0] max_age;
        int          i;
        int          start;
        bit          done;
        r = '0;
        case (cmd)
            CMD_ACCUM, CMD_REMOVE: begin
                if (uk == USAGE_BAD) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    k = {uk, col, rel};
                    start = home_of(rel, col, uk);
                    i = start;
                    done = 1'b0;
                    while (!done) begin
                        done = 1'b1;
                        if (!shadow_valid[i]) begin
                            if (cmd == CMD_REMOVE) begin
                                r.status = ST_NOTFOUND;
                            end else begin
                                shadow_valid[i] = 1'b1;
                                shadow_key[i]   = k;
                                shadow_count[i] = 32'd1;
                                shadow_rent[i]  = {8'd0, cost};
                                shadow_time[i]  = tm;
                                r.status = ST_CREATED;
                                r.slot   = 11'(i);
                                r.used   = 1'b1;
                                r = with_entry(r, i);
                            end
                        end else if (shadow_key[i] == k) begin
                            r.slot = 11'(i);
                            if (cmd == CMD_REMOVE) begin
                                r.status = ST_REMOVED;
                                r = with_entry(r, i);
                                clear_shadow(i);
                            end else begin
                                if (shadow_count[i] != '1) shadow_count[i]++;
                                sum = shadow_rent[i] + cost;
                                shadow_rent[i] = sum[48] ? '1 : sum[47:0];
                                shadow_time[i] = tm;
                                r.status = ST_UPDATED;
                                r.used   = 1'b1;
                                r = with_entry(r, i);
                            end
                        end else begin
                            i = (i + 1) % SLOTS;
                            if (i == start) begin
                                r.status = (cmd == CMD_REMOVE) ? ST_NOTFOUND : ST_FULL;
                                r.slot   = (cmd == CMD_REMOVE) ? 11'd0 : 11'(start);
                            end else begin
                                done = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_EVICT: begin
                max_age = shadow_window * 64'd86400000000;
                for (i = 0; i < SLOTS; i++) begin
                    if (shadow_valid[i] && shadow_time[i] != 0 && tm > shadow_time[i] &&
                        {1'b0, tm - shadow_time[i]} > max_age) begin
                        clear_shadow(i);
                        if (r.evicted != EVICT_MAX) r.evicted++;
                    end
                end
                r.status = ST_SWEPT;
            end
            default: begin
                r.status = ST_READ;
                r.slot   = sidx;
                if (shadow_valid[sidx]) begin
                    r.used = 1'b1;
                    r = with_entry(r, sidx);
                end
            end
        endcase
        return r;
    endfunction

    // present one command and wait for it to be taken; tvalid stays high
    task automatic send_command(input logic [1:0] cmd, input logic [31:0] rel,
                                input logic [15:0] col, input logic [1:0] uk,
                                input logic [39:0] cost, input logic [62:0] tm,
                                input logic [10:0] sidx, output t_result predicted);
        while (!no_idle && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'd0, sidx, tm, cost, uk, col, rel};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = table_update(cmd, rel, col, uk, cost, tm, sidx);
        pending_results.push_back(predicted);
        items_sent++;
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [11:0] days);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= days;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_window = days;
        @(posedge i_clk);
    endtask

    task automatic random_command;
        t_result     p;
        int          pick;
        int          op;
        logic [31:0] rel;
        logic [15:0] col;
        logic [1:0]  uk;
        logic [39:0] cost;
        logic [62:0] tm;
        logic [10:0] sidx;
        pick = $urandom_range(47);
        rel  = pool_rel[pick];
        col  = pool_col[pick];
        uk   = pool_use[pick];
        cost = {8'($urandom_range(255)), $urandom};
        if ($urandom_range(7) == 0) cost = cost >> $urandom_range(39);
        clock_us = clock_us + 63'($urandom_range(1 << 20)) * 63'd65536;
        tm = clock_us;
        case ($urandom_range(19))
            0:       tm = 63'({$urandom, $urandom});
            1:       tm = '0;
            default: ;
        endcase
        sidx = ($urandom_range(1) == 0) ? 11'(home_of(rel, col, uk) + $urandom_range(3))
                                        : 11'($urandom);
        op = $urandom_range(99);
        if (op < 55) begin
            send_command(CMD_ACCUM, rel, col, uk, cost, tm, sidx, p);
        end else if (op < 70) begin
            send_command(CMD_REMOVE, rel, col, uk, cost, tm, sidx, p);
        end else if (op < 72) begin
            send_command(CMD_EVICT, $urandom, 16'($urandom), 2'($urandom), cost, tm, sidx, p);
        end else if (op < 92) begin
            send_command(CMD_READ, $urandom, 16'($urandom), 2'($urandom), cost, tm, sidx, p);
        end else begin
            // noise: unknown keys, bad usage kind
            send_command(2'($urandom_range(1)), $urandom, 16'($urandom),
                         ($urandom_range(1) == 0) ? USAGE_BAD : 2'($urandom_range(2)),
                         cost, tm, sidx, p);
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status  = m_axis_tuser;
            got.slot    = m_axis_tdata[10:0];
            got.used    = m_axis_tdata[11];
            got.rel     = m_axis_tdata[43:12];
            got.col     = m_axis_tdata[59:44];
            got.usage   = m_axis_tdata[61:60];
            got.count   = m_axis_tdata[93:62];
            got.rent    = m_axis_tdata[141:94];
            got.last    = m_axis_tdata[204:142];
            got.evicted = m_axis_tdata[216:205];
            if (got.status < 7) status_seen[got.status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item: %p", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected %p", exp_r);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_result p;
        int      n;
        for (n = 0; n < 48; n++) begin
            pool_rel[n] = (n % 4 == 0) ? $urandom : pool_rel[n - 1] + 32'd2048;
            pool_col[n] = (n % 4 == 0) ? 16'($urandom) : pool_col[n - 1];
            pool_use[n] = (n % 4 == 0) ? 2'($urandom_range(2)) : pool_use[n - 1];
        end
        for (n = 0; n < SLOTS; n++) clear_shadow(n);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under the reset window
        foreach (directed_rows[r]) begin
            send_command(directed_rows[r].cmd, directed_rows[r].rel, directed_rows[r].col,
                         directed_rows[r].use_kind, directed_rows[r].cost,
                         directed_rows[r].tm, directed_rows[r].sidx, p);
            if (directed_rows[r].chk && p.status != directed_rows[r].st) begin
                mismatches++;
                $display("row %0d: table status %0d, predictor %0d", r,
                         directed_rows[r].st, p.status);
            end
        end

        write_window(12'd3650);
        for (n = 0; n < 250; n++) random_command();

        write_window(12'd0);
        for (n = 0; n < 300; n++) begin
            no_idle = (n >= 100 && n < 250);
            if (n == 150) drain_results();
            random_command();
        end
        no_idle = 1'b0;

        write_window(12'($urandom_range(3650)));
        // rent saturation on one key at the largest cost
        for (n = 0; n < 260; n++)
            send_command(CMD_ACCUM, pool_rel[0], pool_col[0], pool_use[0], COST_MAX,
                         clock_us, 11'd0, p);
        for (n = 0; n < 150; n++) random_command();

        // sweep at the latest time with a zero window, then read back
        write_window(12'd0);
        send_command(CMD_EVICT, 32'd0, 16'd0, 2'd0, 40'd0, TIME_MAX, 11'd0, p);
        send_command(CMD_READ, 32'd0, 16'd0, 2'd0, 40'd0, 63'd0, 11'd2047, p);
        send_command(CMD_EVICT, 32'd0, 16'd0, 2'd0, 40'd0, 63'd50, 11'd0, p);

        write_window(12'd3650);
        for (n = 0; n < 60; n++) random_command();

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("%0d commands: %0d updated, %0d created, %0d full, %0d removed,",
                 items_sent, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("  %0d not found, %0d sweeps, %0d reads; %0d mismatches",
                 status_seen[4], status_seen[5], status_seen[6], mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cuha_pkg.sv
rtl/core/cuha_hash.sv
rtl/core/cuha_table.sv
rtl/core/column_usage_hash_accumulator.sv
tb/column_usage_hash_accumulator_tb.sv
